// ===== rtl/slw_pkg.sv =====
`timescale 1ns / 1ps

package slw_pkg;

    localparam int BYTES_PER_FRAME = 16;
    localparam int BYTE_CNT_W = 5;
    localparam int SLOT_W = 17;
    localparam int SLOT_CNT_W = 5;

    localparam logic [2:0] HDR_COMMAND = 3'b100;
    localparam logic [2:0] HDR_WRITE = 3'b101;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_DISPLAY = 1'b1;

    localparam logic [SLOT_CNT_W-1:0] SLOTS_REJECT = 5'd1;
    localparam logic [SLOT_CNT_W-1:0] SLOTS_COMMAND = 5'd12;
    localparam logic [SLOT_CNT_W-1:0] SLOTS_OPEN = 5'd17;
    localparam logic [SLOT_CNT_W-1:0] SLOTS_BYTE = 5'd8;

    typedef struct packed {
        logic       kind;
        logic       chip;
        logic [7:0] value;
    } req_item_t;

    typedef struct packed {
        logic cs_first_n;
        logic cs_second_n;
        logic data_bit;
        logic frame_end;
        logic rejected;
        logic last;
    } slot_item_t;

    typedef struct packed {
        logic load;
        logic shift;
    } shift_ctrl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } slw_state_t;

endpackage

// ===== rtl/slw_shifter.sv =====
`timescale 1ns / 1ps

module slw_shifter
    import slw_pkg::*;
(
    input  logic              clk,
    input  shift_ctrl_t       ctrl,
    input  logic [SLOT_W-1:0] load_word,
    output logic              msb
);

    logic [SLOT_W-1:0] word_reg;
    logic [SLOT_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = load_word;
        end
        else if (ctrl.shift)
        begin
            word_next = {word_reg[SLOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign msb = word_reg[SLOT_W-1];

endmodule

// ===== rtl/slw_seq.sv =====
`timescale 1ns / 1ps

module slw_seq
    import slw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_item_t         req,
    output logic              slot_valid,
    input  logic              slot_stall,
    output slot_item_t        slot,
    output shift_ctrl_t       ctrl,
    output logic [SLOT_W-1:0] load_word,
    input  logic              msb
);

    slw_state_t            state_reg, state_next;
    logic [SLOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  frame_open_reg, frame_open_next;
    logic                  frame_chip_reg, frame_chip_next;
    logic [BYTE_CNT_W-1:0] bytes_sent_reg, bytes_sent_next;
    logic                  chip_reg, chip_next;
    logic                  fend_reg, fend_next;
    logic                  rej_reg, rej_next;
    logic                  out_valid_reg, out_valid_next;
    slot_item_t            out_reg, out_next;
    logic                  accept;
    logic                  emit;
    logic                  final_slot;
    logic [BYTE_CNT_W:0]   bytes_inc;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept = req_valid && !req_stall;
    assign emit = (state_reg == ST_SHIFT) && (!out_valid_reg || !slot_stall);
    assign final_slot = (cnt_reg == SLOT_CNT_W'(1));
    assign bytes_inc = {1'b0, bytes_sent_reg} + (BYTE_CNT_W+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        frame_open_next = frame_open_reg;
        frame_chip_next = frame_chip_reg;
        bytes_sent_next = bytes_sent_reg;
        chip_next = chip_reg;
        fend_next = fend_reg;
        rej_next = rej_reg;
        out_valid_next = out_valid_reg && slot_stall;
        out_next = out_reg;
        ctrl = '0;
        load_word = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load = 1'b1;
                    state_next = ST_SHIFT;
                    rej_next = 1'b0;
                    fend_next = 1'b0;
                    if (req.kind == KIND_COMMAND)
                    begin
                        if (frame_open_reg)
                        begin
                            cnt_next = SLOTS_REJECT;
                            rej_next = 1'b1;
                            chip_next = frame_chip_reg;
                        end
                        else
                        begin
                            load_word = {HDR_COMMAND, req.value, req.value[0], 5'b0};
                            cnt_next = SLOTS_COMMAND;
                            fend_next = 1'b1;
                            chip_next = req.chip;
                        end
                    end
                    else
                    begin
                        if (frame_open_reg)
                        begin
                            load_word = {req.value, 9'b0};
                            cnt_next = SLOTS_BYTE;
                            chip_next = frame_chip_reg;
                        end
                        else
                        begin
                            load_word = {HDR_WRITE, 6'b0, req.value};
                            cnt_next = SLOTS_OPEN;
                            chip_next = req.chip;
                            frame_chip_next = req.chip;
                        end
                        if (frame_open_reg
                            && bytes_inc >= (BYTE_CNT_W+1)'(BYTES_PER_FRAME)
                            || !frame_open_reg && BYTES_PER_FRAME == 1)
                        begin
                            fend_next = 1'b1;
                            frame_open_next = 1'b0;
                            bytes_sent_next = '0;
                        end
                        else
                        begin
                            frame_open_next = 1'b1;
                            bytes_sent_next = frame_open_reg ? bytes_inc[BYTE_CNT_W-1:0]
                                                             : BYTE_CNT_W'(1);
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                if (emit)
                begin
                    ctrl.shift = 1'b1;
                    out_valid_next = 1'b1;
                    out_next.cs_first_n = chip_reg;
                    out_next.cs_second_n = ~chip_reg;
                    out_next.data_bit = msb;
                    out_next.frame_end = fend_reg && final_slot;
                    out_next.rejected = rej_reg;
                    out_next.last = final_slot;
                    cnt_next = cnt_reg - SLOT_CNT_W'(1);
                    if (final_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            frame_open_reg <= 1'b0;
            frame_chip_reg <= 1'b0;
            bytes_sent_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            frame_open_reg <= frame_open_next;
            frame_chip_reg <= frame_chip_next;
            bytes_sent_reg <= bytes_sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chip_reg <= chip_next;
        fend_reg <= fend_next;
        rej_reg <= rej_next;
        out_reg <= out_next;
    end

    assign slot_valid = out_valid_reg;
    assign slot = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid && slot.rejected |-> slot.last && !slot.data_bit)
        else $error("A rejected item must be a single zero slot.");

    assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid && slot.frame_end |-> slot.last && !slot.rejected)
        else $error("A frame end must close the item.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cnt_reg == '0)
        else $error("Slot counter must be empty while idle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit && final_slot |=> state_reg == ST_IDLE)
        else $error("Sequencer must return to idle after the final slot.");

endmodule

// ===== rtl/segment_lcd_serial_writer_unit.sv =====
`timescale 1ns / 1ps

// Each item is loaded into the shift register and sent as bit slots: 1 slot for a
// rejected command, 12 for a command, 17 for the byte that opens a frame, 8 otherwise.
// Each slot is registered before it appears; the single shift register emits one slot
// per cycle while slot_stall is low, and the next item is taken after the last slot.
// Reset is asynchronous and active low; it closes any open frame and empties the output.
module segment_lcd_serial_writer_unit
    import slw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_item_t  req,
    output logic       slot_valid,
    input  logic       slot_stall,
    output slot_item_t slot
);

    shift_ctrl_t       ctrl;
    logic [SLOT_W-1:0] load_word;
    logic              msb;

    slw_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .slot_valid (slot_valid),
        .slot_stall (slot_stall),
        .slot       (slot),
        .ctrl       (ctrl),
        .load_word  (load_word),
        .msb        (msb)
    );

    slw_shifter u_shifter (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_word (load_word),
        .msb       (msb)
    );

endmodule
